// ----- design/vpa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and codes for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam logic [15:0] POOL_RESET = 16'd1024;

	// request codes
	localparam logic [2:0] ACT_FIRST   = 3'd0;
	localparam logic [2:0] ACT_BEST    = 3'd1;
	localparam logic [2:0] ACT_WORST   = 3'd2;
	localparam logic [2:0] ACT_RELEASE = 3'd3;
	localparam logic [2:0] ACT_INIT    = 3'd4;

	// result codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// one partition table entry
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic        used;
		logic [15:0] owner;
	} entry_t;

endpackage
`default_nettype wire

// ----- design/vpa_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_cell
// One partition entry of the table ring; loads its neighbor when shifting.
// ----------------------------------------------------------------------------
module vpa_cell #(
	parameter logic [15:0] RESET_LENGTH = 16'd0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              shift,
	input  vpa_pkg::entry_t  d,
	output vpa_pkg::entry_t  q
);
	import vpa_pkg::*;

	entry_t entry_q;

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{start: 16'd0, length: RESET_LENGTH, used: 1'b0, owner: 16'd0};
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

// ----- design/vpa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: a scan pass over the ring picks the partition; if the table
// changes, an edit pass rewrites it in place; the result beat is registered.
// ----------------------------------------------------------------------------
module vpa_ctrl #(
	parameter int MAX_PARTITIONS = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire [2:0]        action,
	input  wire [15:0]       request_size,
	input  wire [15:0]       block_id,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [2:0]       status,
	output logic [15:0]      granted_id,
	output logic [15:0]      granted_address,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [15:0]       cfg_data,
	input  vpa_pkg::entry_t  head,
	input  vpa_pkg::entry_t  tap1,
	input  vpa_pkg::entry_t  tap2,
	output vpa_pkg::entry_t  tail,
	output logic             shift
);
	import vpa_pkg::*;

	localparam int IW = (MAX_PARTITIONS > 2) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CW = $clog2(MAX_PARTITIONS + 1);
	localparam logic [IW-1:0] LAST = IW'(MAX_PARTITIONS - 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PARTITIONS);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EDIT, S_DONE} state_t;
	typedef enum logic [2:0] {E_NONE, E_MODIFY, E_INSERT, E_RELEASE, E_INIT} edit_t;

	state_t        state_q;
	edit_t         mode_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [2:0]    act_q;
	logic [15:0]   size_q;
	logic [15:0]   bid_q;
	logic [15:0]   pool_q;
	logic [15:0]   id_q;
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [15:0]   plen_q;
	logic [15:0]   pstart_q;
	logic          prev_used_q;
	logic          merge_l_q;
	logic          merge_r_q;
	logic          chk_next_q;
	logic [IW-1:0] tgt_q;
	logic [1:0]    del_q;
	entry_t        hold_q;
	logic [2:0]    res_status_q;
	logic [15:0]   res_id_q;
	logic [15:0]   res_addr_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [15:0]   gid_q;
	logic [15:0]   gaddr_q;

	logic          in_range;
	logic          is_alloc;
	logic          fits;
	logic          better;
	logic          match;
	logic [15:0]   new_id;
	logic [15:0]   tap_sum;
	logic          can_load;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign granted_id      = gid_q;
	assign granted_address = gaddr_q;
	assign shift     = (state_q == S_SCAN) || (state_q == S_EDIT);
	assign can_load  = !out_valid_q || !out_stall;

	// scan terms for the entry at the head of the ring
	always_comb begin
		in_range = (CW'(k_q) < count_q);
		is_alloc = (act_q == ACT_FIRST) || (act_q == ACT_BEST) || (act_q == ACT_WORST);
		fits     = in_range && !head.used && (head.length >= size_q);
		better   = ((act_q == ACT_BEST) && (head.length < plen_q)) ||
		           ((act_q == ACT_WORST) && (head.length > plen_q));
		match    = in_range && head.used && (bid_q != 16'd0) &&
		           (head.owner == bid_q) && !found_q;
		new_id   = (id_q == 16'hFFFF) ? 16'd1 : id_q + 16'd1;
		tap_sum  = head.length + (del_q != 2'd0 ? tap1.length : 16'd0) +
		           (del_q == 2'd2 ? tap2.length : 16'd0);
	end

	// data fed back into the tail cell during the edit pass
	always_comb begin
		tail = head;
		if (state_q == S_EDIT) begin
			case (mode_q)
				E_MODIFY: begin
					if (k_q == pick_q) begin
						tail = '{start: head.start, length: size_q, used: 1'b1, owner: id_q};
					end
				end
				E_INSERT: begin
					if (k_q == pick_q) begin
						tail = '{start: head.start, length: size_q, used: 1'b1, owner: id_q};
					end else if (k_q > pick_q) begin
						tail = hold_q;
					end
				end
				E_RELEASE: begin
					if (k_q == tgt_q) begin
						tail = '{start: head.start, length: tap_sum, used: 1'b0, owner: 16'd0};
					end else if (k_q > tgt_q) begin
						tail = (del_q == 2'd2) ? tap2 : (del_q == 2'd1) ? tap1 : head;
					end
				end
				E_INIT: begin
					if (k_q == '0) begin
						tail = '{start: 16'd0, length: pool_q, used: 1'b0, owner: 16'd0};
					end
				end
				default: tail = head;
			endcase
		end
	end

	// pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
		end else if (cfg_valid) begin
			pool_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= E_NONE;
			k_q          <= '0;
			count_q      <= CW'(1);
			id_q         <= 16'd0;
			found_q      <= 1'b0;
			merge_l_q    <= 1'b0;
			merge_r_q    <= 1'b0;
			chk_next_q   <= 1'b0;
			prev_used_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q       <= action;
						size_q      <= request_size;
						bid_q       <= block_id;
						k_q         <= '0;
						found_q     <= 1'b0;
						merge_l_q   <= 1'b0;
						merge_r_q   <= 1'b0;
						chk_next_q  <= 1'b0;
						prev_used_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					prev_used_q <= head.used;
					if (is_alloc) begin
						if (fits && !found_q) begin
							found_q  <= 1'b1;
							pick_q   <= k_q;
							plen_q   <= head.length;
							pstart_q <= head.start;
						end else if (fits && better) begin
							pick_q   <= k_q;
							plen_q   <= head.length;
							pstart_q <= head.start;
						end
					end else if (match) begin
						found_q    <= 1'b1;
						pick_q     <= k_q;
						merge_l_q  <= (k_q != '0) && !prev_used_q;
						chk_next_q <= 1'b1;
					end else if (chk_next_q) begin
						chk_next_q <= 1'b0;
						merge_r_q  <= in_range && !head.used;
					end
					if (k_q == LAST) begin
						k_q     <= '0;
						state_q <= S_DECIDE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (is_alloc && (size_q != 16'd0) && found_q &&
					    ((plen_q == size_q) || (count_q != FULL))) begin
						id_q         <= new_id;
						res_status_q <= ST_OK;
						res_id_q     <= new_id;
						res_addr_q   <= pstart_q;
						mode_q       <= (plen_q == size_q) ? E_MODIFY : E_INSERT;
						hold_q       <= '{start: pstart_q + size_q,
						                  length: plen_q - size_q,
						                  used: 1'b0, owner: 16'd0};
						state_q      <= S_EDIT;
					end else if ((act_q == ACT_RELEASE) && found_q) begin
						res_status_q <= ST_OK;
						res_id_q     <= 16'd0;
						res_addr_q   <= 16'd0;
						mode_q       <= E_RELEASE;
						tgt_q        <= merge_l_q ? pick_q - 1'b1 : pick_q;
						del_q        <= {1'b0, merge_l_q} + {1'b0, merge_r_q};
						state_q      <= S_EDIT;
					end else if (act_q == ACT_INIT) begin
						res_status_q <= ST_OK;
						res_id_q     <= 16'd0;
						res_addr_q   <= 16'd0;
						mode_q       <= E_INIT;
						state_q      <= S_EDIT;
					end else begin
						// table left as it is
						res_id_q   <= 16'd0;
						res_addr_q <= 16'd0;
						mode_q     <= E_NONE;
						state_q    <= S_DONE;
						if (!is_alloc) begin
							res_status_q <= (act_q == ACT_RELEASE) ? ST_UNKNOWN : ST_OK;
						end else if (size_q == 16'd0) begin
							res_status_q <= ST_ZERO;
						end else if (!found_q) begin
							res_status_q <= ST_NOFIT;
						end else begin
							res_status_q <= ST_FULL;
						end
					end
				end
				S_EDIT: begin
					// insert: each displaced entry passes through the hold register
					if ((mode_q == E_INSERT) && (k_q > pick_q)) begin
						hold_q <= head;
					end
					if (k_q == LAST) begin
						k_q     <= '0;
						state_q <= S_DONE;
						case (mode_q)
							E_INSERT:  count_q <= count_q + 1'b1;
							E_RELEASE: count_q <= count_q - CW'(del_q);
							E_INIT:    count_q <= CW'(1);
							default:   count_q <= count_q;
						endcase
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DONE: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						gid_q       <= res_id_q;
						gaddr_q     <= res_addr_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/variable_partition_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// Address-ordered partition table kept in a ring of cells, with first, best
// and worst fit allocation, release with merging, and re-initialise.
// ----------------------------------------------------------------------------
// One request at a time, the next is taken the cycle after the result is
// registered; the ring rotates once to scan and, for requests that change
// the table, once more to edit.
// Reset: table holds one free partition of 1024 units, id counter zero,
// pool size 1024.
module variable_partition_allocator_unit #(
	parameter int MAX_PARTITIONS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire [2:0]   action,
	input  wire [15:0]  request_size,
	input  wire [15:0]  block_id,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [15:0] granted_id,
	output logic [15:0] granted_address,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [15:0]  cfg_data
);
	import vpa_pkg::*;

	localparam int TAP2 = (MAX_PARTITIONS > 2) ? 2 : 0;

	entry_t cell_q [MAX_PARTITIONS];
	entry_t tail;
	logic   shift;

	// ring of cells: each takes its upper neighbor, the last takes the tail
	for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
		vpa_cell #(
			.RESET_LENGTH((i == 0) ? POOL_RESET : 16'd0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      ((i == MAX_PARTITIONS - 1) ? tail : cell_q[(i + 1) % MAX_PARTITIONS]),
			.q      (cell_q[i])
		);
	end

	// sequencer
	vpa_ctrl #(
		.MAX_PARTITIONS(MAX_PARTITIONS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.request_size    (request_size),
		.block_id        (block_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_id      (granted_id),
		.granted_address (granted_address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.head            (cell_q[0]),
		.tap1            (cell_q[1]),
		.tap2            (cell_q[TAP2]),
		.tail            (tail),
		.shift           (shift)
	);

endmodule
`default_nettype wire

// ----- sim/variable_partition_allocator_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit_tb
// Drives allocate, release and re-initialise requests through the request
// channel, predicts every answer with a local copy of the partition table and
// compares each answer beat field by field. Pool size is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module variable_partition_allocator_unit_tb;
	import vpa_pkg::*;

	localparam int NPART = 16;
	localparam int SETTLE = 2 * NPART + 12;
	localparam int WD_LIMIT = 4000;

	typedef struct packed {
		logic [2:0]  act;
		logic [15:0] size;
		logic [15:0] bid;
	} req_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] gid;
		logic [15:0] gaddr;
	} ans_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = '0;
	logic [15:0] request_size = '0;
	logic [15:0] block_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] granted_id;
	logic [15:0] granted_address;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	variable_partition_allocator_unit #(.MAX_PARTITIONS(NPART)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .request_size(request_size), .block_id(block_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .granted_id(granted_id), .granted_address(granted_address),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// predicted partition table
	entry_t      tbl [NPART];
	int          tbl_cnt;
	logic [15:0] pool_units;
	logic [15:0] last_id;

	req_t pending_reqs [$];
	ans_t expected_answers [$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_granted = 0;
	bit   quiet = 1'b0;
	bit   hold_send = 1'b0;

	function automatic void add_req(req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	function automatic void table_init();
		for (int k = 0; k < NPART; k++) tbl[k] = '0;
		tbl[0].length = pool_units;
		tbl_cnt = 1;
	endfunction

	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < tbl_cnt; j++) tbl[j] = tbl[j + 1];
		tbl_cnt--;
		tbl[tbl_cnt] = '0;
	endfunction

	function automatic ans_t predict_answer(req_t r);
		ans_t a;
		int pick;
		bit found;
		int i;
		a = '0;
		a.st = ST_OK;
		if (r.act <= ACT_WORST) begin
			found = 1'b0;
			pick = 0;
			if (r.size == 0) begin
				a.st = ST_ZERO;
				return a;
			end
			for (i = 0; i < tbl_cnt; i++) begin
				if (tbl[i].used || tbl[i].length < r.size) continue;
				if (!found) begin
					pick = i;
					found = 1'b1;
					if (r.act == ACT_FIRST) break;
				end else if (r.act == ACT_BEST && tbl[i].length < tbl[pick].length) begin
					pick = i;
				end else if (r.act == ACT_WORST && tbl[i].length > tbl[pick].length) begin
					pick = i;
				end
			end
			if (!found) begin
				a.st = ST_NOFIT;
				return a;
			end
			if (tbl[pick].length != r.size && tbl_cnt >= NPART) begin
				a.st = ST_FULL;
				return a;
			end
			last_id = last_id + 16'd1;
			if (last_id == 0) last_id = 16'd1;
			if (tbl[pick].length != r.size) begin
				for (int j = tbl_cnt; j > pick; j--) tbl[j] = tbl[j - 1];
				tbl_cnt++;
				tbl[pick + 1].start = tbl[pick].start + r.size;
				tbl[pick + 1].length = tbl[pick].length - r.size;
				tbl[pick + 1].used = 1'b0;
				tbl[pick + 1].owner = '0;
				tbl[pick].length = r.size;
			end
			tbl[pick].used = 1'b1;
			tbl[pick].owner = last_id;
			a.gid = last_id;
			a.gaddr = tbl[pick].start;
		end else if (r.act == ACT_RELEASE) begin
			for (i = 0; i < tbl_cnt; i++)
				if (tbl[i].used && r.bid != 0 && tbl[i].owner == r.bid) break;
			if (i >= tbl_cnt) begin
				a.st = ST_UNKNOWN;
				return a;
			end
			tbl[i].used = 1'b0;
			tbl[i].owner = '0;
			if (i + 1 < tbl_cnt && !tbl[i + 1].used) begin
				tbl[i].length = tbl[i].length + tbl[i + 1].length;
				drop_entry(i + 1);
			end
			if (i > 0 && !tbl[i - 1].used) begin
				tbl[i - 1].length = tbl[i - 1].length + tbl[i].length;
				drop_entry(i);
			end
		end else if (r.act == ACT_INIT) begin
			table_init();
		end
		return a;
	endfunction

	// driver: one beat per request, payload held while stalled
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_answers = {expected_answers, predict_answer(pending_reqs.pop_front())};
				n_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0 && in_valid) begin
					gap_left = $urandom_range(1, 7) - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_send) begin
					in_valid <= 1'b1;
					action <= pending_reqs[0].act;
					request_size <= pending_reqs[0].size;
					block_id <= pending_reqs[0].bid;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each answer beat with the oldest prediction
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected answer st=%0d id=%0d addr=%0d", $time,
						status, granted_id, granted_address);
					errors++;
				end else begin
					ans_t e;
					e = expected_answers.pop_front();
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errors++;
					end
					if (granted_id !== e.gid) begin
						$display("%0t: granted_id expected %0d actual %0d", $time, e.gid,
							granted_id);
						errors++;
					end
					if (granted_address !== e.gaddr) begin
						$display("%0t: granted_address expected %0d actual %0d", $time,
							e.gaddr, granted_address);
						errors++;
					end
					if (e.st == ST_OK && e.gid != 0) n_granted++;
					n_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any accepted beat
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WD_LIMIT);
			$display("variable_partition_allocator_unit_tb: errors");
			$finish;
		end
	end

	function automatic req_t mk(logic [2:0] a, logic [15:0] s, logic [15:0] b);
		req_t r;
		r.act = a;
		r.size = s;
		r.bid = b;
		return r;
	endfunction

	// random size: mostly small relative to the pool, sometimes anything
	function automatic logic [15:0] rand_size();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 16'($urandom);
		if (sel == 1) return 16'd0;
		if (pool_units == 0) return 16'($urandom_range(1, 4));
		return 16'($urandom_range(1, (pool_units / 6) + 1));
	endfunction

	task automatic queue_random(int n);
		int sel;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 19);
			if (sel < 10)
				add_req(mk(3'($urandom_range(0, 2)), rand_size(),
					16'($urandom)));
			else if (sel < 17)
				// release: by a plausible id or a random one
				add_req(mk(ACT_RELEASE, 16'($urandom),
					(sel < 16 && last_id != 0) ?
					16'($urandom_range(1, last_id + 3)) : 16'($urandom)));
			else if (sel == 17)
				add_req(mk(ACT_INIT, 16'($urandom), 16'($urandom)));
			else if (sel == 18 && k % 3 == 0)
				add_req(mk(3'($urandom_range(5, 7)), 16'($urandom),
					16'($urandom)));
			else
				add_req(mk(ACT_FIRST, rand_size(), 16'($urandom)));
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_answers.size() > 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pool(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pool_units = v;
	endtask

	initial begin
		pool_units = POOL_RESET;
		last_id = '0;
		table_init();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero size, every fit, exact fit, unknown ids, merges, odd codes
		add_req(mk(ACT_FIRST, 16'd0, 16'd0));
		add_req(mk(ACT_FIRST, 16'hFFFF, 16'hFFFF));
		add_req(mk(ACT_FIRST, 16'd100, 16'd0));
		add_req(mk(ACT_FIRST, 16'd50, 16'd0));
		add_req(mk(ACT_FIRST, 16'd200, 16'd0));
		add_req(mk(ACT_FIRST, 16'd10, 16'd0));
		add_req(mk(ACT_RELEASE, 16'd0, 16'd1));
		add_req(mk(ACT_RELEASE, 16'd0, 16'd3));
		add_req(mk(ACT_BEST, 16'd40, 16'd0));
		add_req(mk(ACT_WORST, 16'd40, 16'd0));
		add_req(mk(ACT_FIRST, 16'd60, 16'd0));
		add_req(mk(ACT_RELEASE, 16'd0, 16'd0));
		add_req(mk(ACT_RELEASE, 16'd0, 16'hFFFF));
		add_req(mk(ACT_RELEASE, 16'd0, 16'd2));
		add_req(mk(ACT_RELEASE, 16'd0, 16'd4));
		add_req(mk(3'd5, 16'hFFFF, 16'hFFFF));
		add_req(mk(3'd7, 16'd0, 16'd0));
		add_req(mk(ACT_FIRST, 16'd1024, 16'd0));
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		for (int k = 0; k < 17; k++)
			add_req(mk(ACT_FIRST, 16'd1, 16'd0));
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		drain();

		// pool extremes and a few ordinary sizes
		write_pool(16'd0);
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		add_req(mk(ACT_WORST, 16'd1, 16'd0));
		drain();
		write_pool(16'hFFFF);
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		add_req(mk(ACT_FIRST, 16'hFFFF, 16'd0));
		queue_random(150);
		// sender holds off until every answer is in
		hold_send = 1'b1;
		while (expected_answers.size() > 0 || in_valid) @(posedge clk);
		hold_send = 1'b0;
		drain();
		write_pool(16'd1);
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		queue_random(100);
		drain();
		write_pool(16'd96);
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		queue_random(250);
		drain();
		write_pool(16'($urandom_range(200, 4000)));
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		queue_random(250);
		drain();
		// last stretch with no idling on either side
		quiet = 1'b1;
		write_pool(16'd1024);
		add_req(mk(ACT_INIT, 16'd0, 16'd0));
		queue_random(150);
		drain();

		$display("covered %0d requests, %0d answers checked, %0d grants", n_sent,
			n_checked, n_granted);
		$display("pool sizes 0, 1, 96, 1024, 65535 and one random; all fits and releases");
		if (errors == 0 && expected_answers.size() == 0)
			$display("variable_partition_allocator_unit_tb: clean");
		else
			$display("variable_partition_allocator_unit_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
design/vpa_pkg.sv
design/vpa_cell.sv
design/vpa_ctrl.sv
design/variable_partition_allocator_unit.sv
sim/variable_partition_allocator_unit_tb.sv
